// ===== rtl/sssct_pkg.sv =====
// ----------------------------------------------------------------------------
// sssct_pkg
// shared constants and types of the swept sphere-sphere contact time unit
// ----------------------------------------------------------------------------
`default_nettype none

package sssct_pkg;

    // default coordinate width and fraction bits
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // width of the reported contact time
    localparam int TIME_WIDTH = 32;

    // classification carried alongside the square root
    typedef struct packed {
        logic b_neg;   // centres approaching
        logic c_pos;   // spheres separate at time zero
        logic d_neg;   // no real root
    } sssct_flags_t;

    // result selection carried alongside the divider
    typedef struct packed {
        logic touch;      // contact reported
        logic use_q;      // time comes from the quotient
        logic zero_time;  // time is zero, else all ones
    } sssct_res_t;

endpackage

`default_nettype wire

// ===== rtl/swept_sphere_sphere_contact_time_unit.sv =====
// ----------------------------------------------------------------------------
// swept_sphere_sphere_contact_time_unit
// first contact time of two moving spheres, fully pipelined
// ----------------------------------------------------------------------------
// throughput: one item per cycle unless the result waits; the square root takes one stage per root bit
// and the divider one stage per quotient bit, so these set the depth
// the whole pipeline advances together and holds while the result waits
// reset clears the stage valid bits only; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module swept_sphere_sphere_contact_time_unit
    import sssct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_axis_tvalid,
    output logic      s_axis_tready,
    // rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y, rel_vel_z,
    // radius_first, radius_second, zero fill
    input  wire logic [((8*COORD_WIDTH-2+7)/8)*8-1:0] s_axis_tdata,
    output logic      m_axis_tvalid,
    input  wire logic m_axis_tready,
    // contact_time
    output logic [TIME_WIDTH-1:0] m_axis_tdata,
    // will_touch
    output logic [0:0] m_axis_tuser
);

    localparam int CW   = COORD_WIDTH;
    localparam int MW   = 2*CW;
    localparam int DW   = 4*CW;
    localparam int RW   = MW;
    localparam int NL   = (MW+31)/32;
    localparam int LW   = (MW+NL-1)/NL;
    localparam int PADW = NL*LW;
    localparam int PW   = 2*PADW;
    localparam int TW   = TIME_WIDTH;
    localparam int RMW  = MW+TW;
    localparam int NST  = 6+RW+1+TW;

    // pipeline control
    logic           en;
    logic [NST-1:0] vld_reg;

    assign en            = !vld_reg[NST-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[NST-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end

    // input fields
    logic signed [CW-1:0] dx [3];
    logic signed [CW-1:0] dv [3];
    logic [CW-2:0] rad1;
    logic [CW-2:0] rad2;
    logic [CW-1:0] rsum;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dx[k] = s_axis_tdata[k*CW +: CW];
            dv[k] = s_axis_tdata[(3+k)*CW +: CW];
        end
        rad1 = s_axis_tdata[6*CW +: CW-1];
        rad2 = s_axis_tdata[7*CW-1 +: CW-1];
        rsum = {1'b0, rad1} + {1'b0, rad2};
    end

    // stage 1: elementary products
    logic signed [MW-1:0] pxx_reg [3];
    logic signed [MW-1:0] pvv_reg [3];
    logic signed [MW-1:0] pxv_reg [3];
    logic [MW-1:0] prr_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                pxx_reg[k] <= dx[k] * dx[k];
                pvv_reg[k] <= dv[k] * dv[k];
                pxv_reg[k] <= dx[k] * dv[k];
            end
            prr_reg <= {{CW{1'b0}}, rsum} * {{CW{1'b0}}, rsum};
        end
    end

    // stage 2: dot products
    logic [MW-1:0] a2_next, sxx;
    logic [MW:0]   b2_next, c2_next;
    logic [MW-1:0] a2_reg;
    logic [MW:0]   b2_reg, c2_reg;

    always_comb begin
        a2_next = '0;
        sxx     = '0;
        b2_next = '0;
        for (int k = 0; k < 3; k++) begin
            a2_next = a2_next + pvv_reg[k];
            sxx     = sxx + pxx_reg[k];
            b2_next = b2_next + {pxv_reg[k][MW-1], pxv_reg[k]};
        end
        c2_next = {1'b0, sxx} - {1'b0, prr_reg};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a2_reg <= a2_next;
            b2_reg <= b2_next;
            c2_reg <= c2_next;
        end
    end

    // stage 3: signs and magnitudes
    logic [MW:0]   bneg_full;
    logic [MW-1:0] a3_reg, babs3_reg, cu3_reg;
    sssct_flags_t  flg3_reg;

    assign bneg_full = ~b2_reg + {{MW{1'b0}}, 1'b1};

    always_ff @(posedge aclk) begin
        if (en) begin
            a3_reg         <= a2_reg;
            babs3_reg      <= b2_reg[MW] ? bneg_full[MW-1:0] : b2_reg[MW-1:0];
            cu3_reg        <= c2_reg[MW-1:0];
            flg3_reg.b_neg <= b2_reg[MW];
            flg3_reg.c_pos <= !c2_reg[MW] && (c2_reg != '0);
            flg3_reg.d_neg <= 1'b0;
        end
    end

    // stage 4: limb partial products of b*b and a*c
    logic [PADW-1:0] bpad, apad, cpad;
    logic [2*LW-1:0] pbb_reg [NL][NL];
    logic [2*LW-1:0] pac_reg [NL][NL];
    logic [MW-1:0]   a4_reg, babs4_reg;
    sssct_flags_t    flg4_reg;

    assign bpad = PADW'(babs3_reg);
    assign apad = PADW'(a3_reg);
    assign cpad = PADW'(cu3_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NL; i++) begin
                for (int j = 0; j < NL; j++) begin
                    pbb_reg[i][j] <= {{LW{1'b0}}, bpad[i*LW +: LW]}
                                   * {{LW{1'b0}}, bpad[j*LW +: LW]};
                    pac_reg[i][j] <= {{LW{1'b0}}, apad[i*LW +: LW]}
                                   * {{LW{1'b0}}, cpad[j*LW +: LW]};
                end
            end
            a4_reg    <= a3_reg;
            babs4_reg <= babs3_reg;
            flg4_reg  <= flg3_reg;
        end
    end

    // stage 5: partial product sums
    logic [PW-1:0] bb_sum, ac_sum;
    logic [DW-1:0] bb5_reg, ac5_reg;
    logic [MW-1:0] a5_reg, babs5_reg;
    sssct_flags_t  flg5_reg;

    always_comb begin
        bb_sum = '0;
        ac_sum = '0;
        for (int i = 0; i < NL; i++) begin
            for (int j = 0; j < NL; j++) begin
                bb_sum = bb_sum + ({{(PW-2*LW){1'b0}}, pbb_reg[i][j]} << (LW*(i+j)));
                ac_sum = ac_sum + ({{(PW-2*LW){1'b0}}, pac_reg[i][j]} << (LW*(i+j)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bb5_reg   <= bb_sum[DW-1:0];
            ac5_reg   <= ac_sum[DW-1:0];
            a5_reg    <= a4_reg;
            babs5_reg <= babs4_reg;
            flg5_reg  <= flg4_reg;
        end
    end

    // square root pipeline storage, index 0 is the discriminant
    logic [DW-1:0] sq_rem_reg  [RW+1];
    logic [RW-1:0] sq_root_reg [RW+1];
    logic [MW-1:0] sq_a_reg    [RW+1];
    logic [MW-1:0] sq_babs_reg [RW+1];
    sssct_flags_t  sq_flg_reg  [RW+1];

    // stage 6: discriminant
    always_ff @(posedge aclk) begin
        if (en) begin
            sq_rem_reg[0]        <= bb5_reg - ac5_reg;
            sq_root_reg[0]       <= '0;
            sq_a_reg[0]          <= a5_reg;
            sq_babs_reg[0]       <= babs5_reg;
            sq_flg_reg[0].b_neg  <= flg5_reg.b_neg;
            sq_flg_reg[0].c_pos  <= flg5_reg.c_pos;
            sq_flg_reg[0].d_neg  <= ac5_reg > bb5_reg;
        end
    end

    // square root, one root bit per stage
    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        localparam int K = RW-1-j;
        logic [DW-1:0] trial;
        logic          fits;

        assign trial = ({{(DW-RW){1'b0}}, sq_root_reg[j]} << (K+1))
                     | ({{(DW-1){1'b0}}, 1'b1} << (2*K));
        assign fits  = sq_rem_reg[j] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[j+1]  <= fits ? sq_rem_reg[j] - trial : sq_rem_reg[j];
                sq_root_reg[j+1] <= sq_root_reg[j] | ({{(RW-1){1'b0}}, fits} << K);
                sq_a_reg[j+1]    <= sq_a_reg[j];
                sq_babs_reg[j+1] <= sq_babs_reg[j];
                sq_flg_reg[j+1]  <= sq_flg_reg[j];
            end
        end
    end

    // divider pipeline storage, index 0 is the scaled numerator
    logic [RMW-1:0] dv_rem_reg [TW+1];
    logic [TW-1:0]  dv_q_reg   [TW+1];
    logic [MW-1:0]  dv_a_reg   [TW+1];
    sssct_res_t     dv_res_reg [TW+1];

    // divider set-up: numerator, saturation and case selection
    logic [MW-1:0]  numer;
    logic [RMW-1:0] num_w;
    logic           sat;
    sssct_flags_t   fl;
    sssct_res_t     res_next;

    always_comb begin
        fl    = sq_flg_reg[RW];
        numer = sq_babs_reg[RW] - sq_root_reg[RW];
        num_w = {{(RMW-MW-FRAC_BITS){1'b0}}, numer, {FRAC_BITS{1'b0}}};
        sat   = num_w >= {sq_a_reg[RW], {TW{1'b0}}};
        res_next = '{touch: 1'b0, use_q: 1'b0, zero_time: 1'b0};
        priority if (!fl.b_neg) begin
            res_next.touch = 1'b0;
        end else if (!fl.c_pos) begin
            res_next.touch     = 1'b1;
            res_next.zero_time = 1'b1;
        end else if (fl.d_neg) begin
            res_next.touch = 1'b0;
        end else if (sat) begin
            res_next.touch = 1'b1;
        end else begin
            res_next.touch = 1'b1;
            res_next.use_q = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_rem_reg[0] <= num_w;
            dv_q_reg[0]   <= '0;
            dv_a_reg[0]   <= sq_a_reg[RW];
            dv_res_reg[0] <= res_next;
        end
    end

    // restoring division, one quotient bit per stage
    for (genvar m = 1; m <= TW; m++) begin : g_div
        localparam int I = TW-m;
        logic [RMW-1:0] trial;
        logic           fits;

        assign trial = {{TW{1'b0}}, dv_a_reg[m-1]} << I;
        assign fits  = dv_rem_reg[m-1] >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[m] <= fits ? dv_rem_reg[m-1] - trial : dv_rem_reg[m-1];
                dv_q_reg[m]   <= dv_q_reg[m-1] | ({{(TW-1){1'b0}}, fits} << I);
                dv_a_reg[m]   <= dv_a_reg[m-1];
                dv_res_reg[m] <= dv_res_reg[m-1];
            end
        end
    end

    // result fields
    assign m_axis_tuser[0] = dv_res_reg[TW].touch;
    assign m_axis_tdata    = dv_res_reg[TW].use_q     ? dv_q_reg[TW] :
                             dv_res_reg[TW].zero_time ? {TW{1'b0}}   : {TW{1'b1}};

`ifndef SYNTHESIS
    // no contact always reports the maximum time
    a_no_touch_max: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == {TW{1'b1}}))
        else $error("no-contact result without maximum time");

    // a zero time is always a contact
    a_zero_is_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (m_axis_tdata == {TW{1'b0}})) |-> m_axis_tuser[0])
        else $error("zero time reported without contact");

    // square root remainder stays within twice the root
    a_sqrt_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[5+RW] |-> (sq_rem_reg[RW] <= {{(DW-RW-1){1'b0}}, sq_root_reg[RW], 1'b0}))
        else $error("square root remainder out of range");

    // division remainder ends below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg[NST-1] && dv_res_reg[TW].use_q)
            |-> (dv_rem_reg[TW] < {{TW{1'b0}}, dv_a_reg[TW]}))
        else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire
